/* rtl/cfdu_pkg.sv */
package cfdu_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 13;
   localparam int STATUS_W = 3;
   localparam int CRC_W    = 32;

   localparam logic [LEN_W-1:0]  MAX_BODY       = 13'd4096;
   localparam logic [LEN_W-1:0]  FRAME_OVERHEAD = 13'd13;   // 9 header + 4 crc
   localparam logic [LEN_W-1:0]  MAX_LEN_RESET  = 13'd4096;
   localparam logic [CRC_W-1:0]  CRC_INIT       = 32'hffff_ffff;
   localparam logic [CRC_W-1:0]  CRC_POLY       = 32'hedb8_8320;
   localparam logic [BYTE_W-1:0] VERSION_BYTE   = 8'd1;

   typedef enum logic [2:0] {
      PH_MAGIC,
      PH_VERSION,
      PH_LENGTH,
      PH_BODY,
      PH_CRC
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_RUN     = 3'd0,
      ST_OK      = 3'd1,
      ST_MAGIC   = 3'd2,
      ST_VERSION = 3'd3,
      ST_LENGTH  = 3'd4,
      ST_CRC     = 3'd5
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] body_byte;
      logic              body_valid;
      status_type        frame_status;
      logic [LEN_W-1:0]  body_length;
      logic [LEN_W-1:0]  frame_length;
   } result_type;

   // sync word N C W V
   function automatic logic [BYTE_W-1:0] magic_byte(input logic [1:0] idx);
      logic [BYTE_W-1:0] m;
      unique case (idx)
         2'd0: m = 8'h4e;
         2'd1: m = 8'h43;
         2'd2: m = 8'h57;
         2'd3: m = 8'h56;
         default: m = 8'h00;
      endcase
      return m;
   endfunction

   // reflected crc-32, one byte unrolled
   function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] c_in,
                                                 input logic [BYTE_W-1:0] b);
      logic [CRC_W-1:0] c;
      c = c_in ^ {24'd0, b};
      for (int k = 0; k < BYTE_W; k++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage

/* rtl/cfdu_in_stage.sv */
module cfdu_in_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [cfdu_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                        req_stall,
   input  logic                        advance,
   output logic                        hold_valid,
   output logic [cfdu_pkg::BYTE_W-1:0] hold_byte
);
   import cfdu_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              take;

   // take a new item when empty or when the held one moves on
   assign req_stall = valid_ff & ~advance;
   assign take      = req_valid & ~req_stall;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_rx_byte;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign hold_valid = valid_ff;
   assign hold_byte  = byte_ff;

endmodule

/* rtl/cfdu_frame_fsm.sv */
module cfdu_frame_fsm (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  logic [cfdu_pkg::BYTE_W-1:0] rx_byte,
   input  logic [cfdu_pkg::LEN_W-1:0]  max_body_length,
   output cfdu_pkg::result_type        result
);
   import cfdu_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic              ovf_ff, ovf_in;      // length field above 13 bits
   logic [CRC_W-1:0]  crc_ff, crc_in;
   logic [23:0]       rcv_ff, rcv_in;      // low three crc bytes

   logic [LEN_W-1:0]  limit;
   logic [CRC_W-1:0]  crc_next;
   logic [LEN_W-1:0]  pos_inc;

   assign limit    = (max_body_length > MAX_BODY) ? MAX_BODY : max_body_length;
   assign crc_next = crc_byte(crc_ff, rx_byte);
   assign pos_inc  = pos_ff + LEN_W'(1);

   always_comb begin
      logic hunt;
      hunt     = 1'b0;
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      crc_in   = crc_ff;
      rcv_in   = rcv_ff;
      result   = '{body_byte: '0, body_valid: 1'b0, frame_status: ST_RUN,
                   body_length: '0, frame_length: '0};

      if (step) begin
         unique case (phase_ff)
            PH_MAGIC: begin
               if (rx_byte != magic_byte(pos_ff[1:0])) begin
                  result.frame_status = ST_MAGIC;
                  hunt = 1'b1;
               end else begin
                  crc_in = crc_next;
                  if (pos_ff[1:0] == 2'd3) begin
                     phase_in = PH_VERSION;
                     pos_in   = '0;
                  end else begin
                     pos_in = pos_inc;
                  end
               end
            end
            PH_VERSION: begin
               if (rx_byte != VERSION_BYTE) begin
                  result.frame_status = ST_VERSION;
                  hunt = 1'b1;
               end else begin
                  crc_in   = crc_next;
                  phase_in = PH_LENGTH;
                  pos_in   = '0;
                  len_in   = '0;
                  ovf_in   = 1'b0;
               end
            end
            PH_LENGTH: begin
               crc_in = crc_next;
               unique case (pos_ff[1:0])
                  2'd0: len_in[7:0] = rx_byte;
                  2'd1: begin
                     len_in[LEN_W-1:8] = rx_byte[LEN_W-9:0];
                     ovf_in = ovf_ff | (rx_byte[7:LEN_W-8] != '0);
                  end
                  default: ovf_in = ovf_ff | (rx_byte != '0);
               endcase
               if (pos_ff[1:0] == 2'd3) begin
                  if (ovf_in || (len_in > limit)) begin
                     result.frame_status = ST_LENGTH;
                     hunt = 1'b1;
                  end else begin
                     pos_in   = '0;
                     phase_in = (len_in == '0) ? PH_CRC : PH_BODY;
                  end
               end else begin
                  pos_in = pos_inc;
               end
            end
            PH_BODY: begin
               crc_in            = crc_next;
               result.body_valid = 1'b1;
               result.body_byte  = rx_byte;
               pos_in            = pos_inc;
               if (pos_inc >= len_ff) begin
                  phase_in = PH_CRC;
                  pos_in   = '0;
                  rcv_in   = '0;
               end
            end
            PH_CRC: begin
               unique case (pos_ff[1:0])
                  2'd0: rcv_in[7:0]   = rx_byte;
                  2'd1: rcv_in[15:8]  = rx_byte;
                  2'd2: rcv_in[23:16] = rx_byte;
                  default: ;
               endcase
               if (pos_ff[1:0] == 2'd3) begin
                  if (~crc_ff == {rx_byte, rcv_ff}) begin
                     result.frame_status = ST_OK;
                     result.body_length  = len_ff;
                     result.frame_length = len_ff + FRAME_OVERHEAD;
                  end else begin
                     result.frame_status = ST_CRC;
                  end
                  hunt = 1'b1;
               end else begin
                  pos_in = pos_inc;
               end
            end
            default: hunt = 1'b1;
         endcase

         if (hunt) begin
            phase_in = PH_MAGIC;
            pos_in   = '0;
            len_in   = '0;
            ovf_in   = 1'b0;
            crc_in   = CRC_INIT;
            rcv_in   = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC;
         pos_ff   <= '0;
         len_ff   <= '0;
         ovf_ff   <= 1'b0;
         crc_ff   <= CRC_INIT;
         rcv_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         ovf_ff   <= ovf_in;
         crc_ff   <= crc_in;
         rcv_ff   <= rcv_in;
      end
   end

endmodule

/* rtl/crc32_checked_frame_decoder_unit.sv */
// Frame checker for a received byte stream: magic "NCWV", version 1,
// 32-bit little-endian body length, body, little-endian CRC-32.
// Input channel (req_): one received byte per item on req_rx_byte,
// taken at a clock edge with req_valid high and req_stall low.
// Result channel (rsp_): exactly one result item per input item:
// body byte pass-through with rsp_body_valid, frame status, and on
// status ok the body and whole-frame lengths. Taken when rsp_valid is
// high and rsp_stall low.
// An item taken goes into the input register and then into the result
// register. Throughput: one item per cycle while rsp_stall is low; the
// byte-wide unrolled CRC and the parser state update sit between the
// input register and the result register.
// Stall: a held result blocks the result register; an empty input
// register takes one item, then req_stall rises until the result moves.
// Reset (synchronous, active high) empties both registers, puts the
// parser in hunt for the first magic byte and sets max_body_length to
// 4096. csr_ready is always high; write only while the block is idle.
module crc32_checked_frame_decoder_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [cfdu_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [cfdu_pkg::BYTE_W-1:0]   rsp_body_byte,
   output logic                          rsp_body_valid,
   output logic [cfdu_pkg::STATUS_W-1:0] rsp_frame_status,
   output logic [cfdu_pkg::LEN_W-1:0]    rsp_body_length,
   output logic [cfdu_pkg::LEN_W-1:0]    rsp_frame_length,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cfdu_pkg::LEN_W-1:0]    csr_max_body_length
);
   import cfdu_pkg::*;

   logic [LEN_W-1:0] max_body_length_ff, max_body_length_in;

   logic              hold_valid;
   logic [BYTE_W-1:0] hold_byte;
   logic              advance;
   result_type        result;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff, rsp_in;

   // config register: always ready
   assign csr_ready          = 1'b1;
   assign max_body_length_in = (csr_valid & csr_ready) ? csr_max_body_length
                                                       : max_body_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_body_length_ff <= MAX_LEN_RESET;
      end else begin
         max_body_length_ff <= max_body_length_in;
      end
   end

   // result register may load when empty or being taken
   assign advance = ~rsp_valid_ff | ~rsp_stall;

   cfdu_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .req_stall   (req_stall),
      .advance     (advance),
      .hold_valid  (hold_valid),
      .hold_byte   (hold_byte)
   );

   cfdu_frame_fsm u_frame_fsm (
      .clock           (clock),
      .reset           (reset),
      .step            (hold_valid & advance),
      .rx_byte         (hold_byte),
      .max_body_length (max_body_length_ff),
      .result          (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = hold_valid;
         if (hold_valid) begin
            rsp_in = result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_body_byte    = rsp_ff.body_byte;
   assign rsp_body_valid   = rsp_ff.body_valid;
   assign rsp_frame_status = rsp_ff.frame_status;
   assign rsp_body_length  = rsp_ff.body_length;
   assign rsp_frame_length = rsp_ff.frame_length;

endmodule

/* bench/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import cfdu_pkg::*;

   // cycles with no item moving on any channel before the run is called hung
   localparam int unsigned QUIET_LIMIT = 400;
   // sync word N C W V, first byte in the low lane
   localparam logic [31:0] SYNC_WORD = 32'h5657_434e;
   localparam logic [31:0] CRC_REFLECTED_POLY = 32'hedb8_8320;

   logic clock = 1'b0;
   logic reset;

   logic                req_valid;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_rx_byte;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [BYTE_W-1:0]   rsp_body_byte;
   logic                rsp_body_valid;
   logic [STATUS_W-1:0] rsp_frame_status;
   logic [LEN_W-1:0]    rsp_body_length;
   logic [LEN_W-1:0]    rsp_frame_length;
   logic                csr_valid;
   logic                csr_ready;
   logic [LEN_W-1:0]    csr_max_body_length;

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   crc32_checked_frame_decoder_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_body_byte       (rsp_body_byte),
      .rsp_body_valid      (rsp_body_valid),
      .rsp_frame_status    (rsp_frame_status),
      .rsp_body_length     (rsp_body_length),
      .rsp_frame_length    (rsp_frame_length),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_max_body_length (csr_max_body_length)
   );

   // ---------------------------------------------------------------
   // Frame decoder mirror: parser state and the length register as
   // the block should hold them after every accepted item.
   // ---------------------------------------------------------------
   phase_type        m_phase;
   logic [31:0]      m_pos;
   logic [31:0]      m_len;
   logic [31:0]      m_crc;
   logic [31:0]      m_rx_crc;
   logic [LEN_W-1:0] m_max_len;

   result_type  expected_results[$];
   int unsigned mismatch_count = 0;
   int unsigned sent_count = 0;

   // idling knobs, flipped per test and per random chunk
   bit send_gaps = 1'b1;
   bit recv_stalls = 1'b1;

   // reflected CRC-32, one input bit at a time, LSB first
   function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
      logic [31:0] r;
      r = c;
      for (int i = 0; i < 8; i++) begin
         if (r[0] ^ b[i]) begin
            r = (r >> 1) ^ CRC_REFLECTED_POLY;
         end else begin
            r = r >> 1;
         end
      end
      return r;
   endfunction

   // back to looking for 'N'
   function automatic void restart_hunt();
      m_phase  = PH_MAGIC;
      m_pos    = '0;
      m_len    = '0;
      m_crc    = CRC_INIT;
      m_rx_crc = '0;
   endfunction

   // one received byte in, one result out; updates the mirror state
   function automatic result_type decode_step(input logic [7:0] b);
      result_type  r;
      logic [31:0] limit;
      r = '0;
      r.frame_status = ST_RUN;
      // the register may hold more than the block can ever count to
      limit = (m_max_len > MAX_BODY) ? 32'(MAX_BODY) : 32'(m_max_len);
      case (m_phase)
         PH_MAGIC: begin
            if (b != SYNC_WORD[{m_pos[1:0], 3'b000} +: 8]) begin
               r.frame_status = ST_MAGIC;
               restart_hunt();
            end else begin
               m_crc = crc32_step(m_crc, b);
               if (m_pos >= 3) begin
                  m_phase = PH_VERSION;
                  m_pos   = '0;
               end else begin
                  m_pos++;
               end
            end
         end
         PH_VERSION: begin
            if (b != VERSION_BYTE) begin
               r.frame_status = ST_VERSION;
               restart_hunt();
            end else begin
               m_crc   = crc32_step(m_crc, b);
               m_phase = PH_LENGTH;
               m_pos   = '0;
               m_len   = '0;
            end
         end
         PH_LENGTH: begin
            m_crc = crc32_step(m_crc, b);
            m_len = m_len | (32'(b) << {m_pos[1:0], 3'b000});
            if (m_pos >= 3) begin
               if (m_len > limit) begin
                  r.frame_status = ST_LENGTH;
                  restart_hunt();
               end else begin
                  m_pos   = '0;
                  // empty body skips straight to the crc bytes
                  m_phase = (m_len == 0) ? PH_CRC : PH_BODY;
               end
            end else begin
               m_pos++;
            end
         end
         PH_BODY: begin
            m_crc = crc32_step(m_crc, b);
            r.body_valid = 1'b1;
            r.body_byte  = b;
            m_pos++;
            if (m_pos >= m_len) begin
               m_phase  = PH_CRC;
               m_pos    = '0;
               m_rx_crc = '0;
            end
         end
         default: begin
            m_rx_crc = m_rx_crc | (32'(b) << {m_pos[1:0], 3'b000});
            if (m_pos >= 3) begin
               if (~m_crc == m_rx_crc) begin
                  r.frame_status = ST_OK;
                  r.body_length  = m_len[LEN_W-1:0];
                  r.frame_length = m_len[LEN_W-1:0] + FRAME_OVERHEAD;
               end else begin
                  r.frame_status = ST_CRC;
               end
               restart_hunt();
            end else begin
               m_pos++;
            end
         end
      endcase
      return r;
   endfunction

   function automatic void report_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
      if (exp_v != act_v) begin
         mismatch_count++;
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      end
   endfunction

   // ---------------------------------------------------------------
   // Result side: stall drawn per result item, then check each item
   // taken against the oldest expectation.
   // ---------------------------------------------------------------
   initial begin : result_stall
      int unsigned hold;
      rsp_stall <= 1'b0;
      @(posedge clock);
      forever begin
         hold = recv_stalls ? $urandom_range(0, 8) : 0;
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : result_check
      result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            mismatch_count++;
            $error("result item with no input item waiting for it");
         end else begin
            exp_r = expected_results.pop_front();
            report_field("body_byte", exp_r.body_byte, rsp_body_byte);
            report_field("body_valid", exp_r.body_valid, rsp_body_valid);
            report_field("frame_status", exp_r.frame_status, rsp_frame_status);
            report_field("body_length", exp_r.body_length, rsp_body_length);
            report_field("frame_length", exp_r.frame_length, rsp_frame_length);
         end
      end
   end

   // hang detector: counts cycles in which nothing moves anywhere
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("== FAIL ==");
      $finish;
   end

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------

   // one byte item; predicted at the edge that takes it
   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = send_gaps ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      expected_results.push_back(decode_step(b));
      sent_count++;
   endtask

   // sender holds off until every result is back, then lets the pipe settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [LEN_W-1:0] v);
      wait_idle();
      csr_valid           <= 1'b1;
      csr_max_body_length <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      m_max_len = v;
   endtask

   // Header with the given length field, nbody random body bytes, then the
   // crc over all of it. flip_at >= 0 corrupts that byte before sending.
   task automatic send_frame(input logic [31:0] len_field, input int unsigned nbody,
                             input int flip_at);
      logic [7:0]  frame_bytes[$];
      logic [31:0] c;
      frame_bytes = {};
      for (int i = 0; i < 4; i++) frame_bytes.push_back(SYNC_WORD[8*i +: 8]);
      frame_bytes.push_back(VERSION_BYTE);
      for (int i = 0; i < 4; i++) frame_bytes.push_back(len_field[8*i +: 8]);
      repeat (nbody) frame_bytes.push_back(8'($urandom));
      c = CRC_INIT;
      foreach (frame_bytes[i]) c = crc32_step(c, frame_bytes[i]);
      c = ~c;
      for (int i = 0; i < 4; i++) frame_bytes.push_back(c[8*i +: 8]);
      if (flip_at >= 0 && flip_at < frame_bytes.size()) begin
         frame_bytes[flip_at] ^= 8'($urandom_range(1, 255));
      end
      foreach (frame_bytes[i]) send_byte(frame_bytes[i]);
   endtask

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // short directed stream at reset limit: header errors and an empty frame
   task automatic test_frame_basics();
      send_gaps   = 1'b1;
      recv_stalls = 1'b1;
      send_byte(8'hff);               // junk, bad magic
      send_byte(8'h00);               // junk, bad magic
      // partial sync then 'N' again: bad magic, and that N is not reused
      send_byte(SYNC_WORD[7:0]);
      send_byte(SYNC_WORD[15:8]);
      send_byte(SYNC_WORD[7:0]);
      // good sync, version 0
      for (int i = 0; i < 4; i++) send_byte(SYNC_WORD[8*i +: 8]);
      send_byte(8'h00);
      send_frame(32'd0, 0, -1);       // empty body, ok
   endtask

   // register extremes, lengths on both sides of the limit, crc error,
   // and one long frame under the capped limit
   task automatic test_length_limit();
      write_max_len('0);
      send_frame(32'd0, 0, -1);       // zero body still fits a zero limit
      send_frame(32'd1, 0, -1);       // one over, bad length
      write_max_len(LEN_W'(5));
      send_frame(32'd5, 5, -1);
      send_frame(32'd6, 0, -1);
      send_frame(32'd3, 3, 15);       // last crc byte hit, bad crc
      send_frame(32'hffff_ffff, 0, -1);
      write_max_len('1);              // register above MAX_BODY, block caps it
      send_frame(32'd4097, 0, -1);
      send_frame(32'd1024, 1024, -1);
      write_max_len(MAX_LEN_RESET);
      send_frame(32'd4097, 0, -1);
   endtask

   // mostly well-formed frames with random bodies, the rest corrupted
   // frames, oversize length fields and line noise; new limit and idling
   // mix per chunk
   task automatic test_random_stream();
      int unsigned start, lim, blen, pick;
      logic [31:0] big_len;
      start = sent_count;
      while (sent_count - start < 850) begin
         case ($urandom_range(0, 3))
            0:       write_max_len(MAX_LEN_RESET);
            1:       write_max_len(LEN_W'($urandom_range(0, 64)));
            2:       write_max_len(LEN_W'($urandom));
            default: write_max_len(LEN_W'($urandom_range(4096, 8191)));
         endcase
         send_gaps   = ($urandom_range(0, 2) != 0);
         recv_stalls = ($urandom_range(0, 2) != 0);
         lim = (m_max_len > MAX_BODY) ? MAX_BODY : m_max_len;
         repeat (12) begin
            pick = $urandom_range(0, 99);
            blen = $urandom_range(0, (lim < 48) ? lim : 48);
            if (pick < 65) begin
               send_frame(blen, blen, -1);
            end else if (pick < 82) begin
               send_frame(blen, blen, $urandom_range(0, blen + 12));
            end else if (pick < 90) begin
               if ($urandom_range(0, 1) != 0) begin
                  big_len = $urandom | 32'h0001_0000;
               end else begin
                  big_len = lim + 1 + $urandom_range(0, 200);
               end
               send_frame(big_len, 0, -1);
            end else begin
               // noise, biased toward sync and version bytes
               repeat ($urandom_range(1, 6)) begin
                  if ($urandom_range(0, 1) != 0) begin
                     send_byte(8'($urandom));
                  end else begin
                     case ($urandom_range(0, 5))
                        0:       send_byte(SYNC_WORD[7:0]);
                        1:       send_byte(SYNC_WORD[15:8]);
                        2:       send_byte(SYNC_WORD[23:16]);
                        3:       send_byte(SYNC_WORD[31:24]);
                        4:       send_byte(VERSION_BYTE);
                        default: send_byte(8'h00);
                     endcase
                  end
               end
            end
            // now and then drain fully mid-chunk
            if (pick < 3) wait_idle();
         end
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_rx_byte         <= '0;
      csr_valid           <= 1'b0;
      csr_max_body_length <= '0;
      m_max_len = MAX_LEN_RESET;
      restart_hunt();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_frame_basics();
      test_length_limit();
      test_random_stream();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
